FILE: sv/jhmp_pkg.sv
// Shared types, codes and constants of the JPEG header marker parser.
`default_nettype none
package jhmp_pkg;

  localparam int MaxComponents = 4;
  localparam int QuantTables   = 2;
  localparam int BlockEntries  = 64;
  localparam int HuffTables    = 2;
  localparam int HuffLengths   = 16;
  localparam int HuffSymLimit  = 256;

  // result kinds
  localparam logic [3:0] K_PREC    = 4'd0;
  localparam logic [3:0] K_HEIGHT  = 4'd1;
  localparam logic [3:0] K_WIDTH   = 4'd2;
  localparam logic [3:0] K_NCOMP   = 4'd3;
  localparam logic [3:0] K_COMP    = 4'd4;
  localparam logic [3:0] K_QUANT   = 4'd5;
  localparam logic [3:0] K_HCOUNT  = 4'd6;
  localparam logic [3:0] K_HSYM    = 4'd7;
  localparam logic [3:0] K_RESTART = 4'd8;
  localparam logic [3:0] K_SCAN    = 4'd9;
  localparam logic [3:0] K_DONE    = 4'd10;
  localparam logic [3:0] K_ERROR   = 4'd11;
  localparam logic [3:0] K_UNKNOWN = 4'd12;

  // error codes
  localparam logic [2:0] E_SOF    = 3'd0;
  localparam logic [2:0] E_EOI    = 3'd1;
  localparam logic [2:0] E_TABLE  = 3'd2;
  localparam logic [2:0] E_JFIF   = 3'd3;
  localparam logic [2:0] E_SCANID = 3'd4;
  localparam logic [2:0] E_COUNT  = 3'd5;
  localparam logic [2:0] E_LENGTH = 3'd6;

  // marker codes
  localparam logic [7:0] M_TEM  = 8'h01;
  localparam logic [7:0] M_SOF0 = 8'hC0;
  localparam logic [7:0] M_SOF1 = 8'hC1;
  localparam logic [7:0] M_SOF2 = 8'hC2;
  localparam logic [7:0] M_SOF3 = 8'hC3;
  localparam logic [7:0] M_DHT  = 8'hC4;
  localparam logic [7:0] M_SOF5 = 8'hC5;
  localparam logic [7:0] M_SOF6 = 8'hC6;
  localparam logic [7:0] M_SOF7 = 8'hC7;
  localparam logic [7:0] M_JPG  = 8'hC8;
  localparam logic [7:0] M_SOI  = 8'hD8;
  localparam logic [7:0] M_EOI  = 8'hD9;
  localparam logic [7:0] M_SOS  = 8'hDA;
  localparam logic [7:0] M_DQT  = 8'hDB;
  localparam logic [7:0] M_DRI  = 8'hDD;
  localparam logic [7:0] M_APP0 = 8'hE0;
  localparam logic [7:0] M_FILL = 8'hFF;

  // parse phases
  localparam logic [4:0] PH_SYNC      = 5'd0;
  localparam logic [4:0] PH_MARKER    = 5'd1;
  localparam logic [4:0] PH_LEN_HI    = 5'd2;
  localparam logic [4:0] PH_LEN_LO    = 5'd3;
  localparam logic [4:0] PH_SKIP      = 5'd4;
  localparam logic [4:0] PH_SOF_PREC  = 5'd5;
  localparam logic [4:0] PH_SOF_H_HI  = 5'd6;
  localparam logic [4:0] PH_SOF_H_LO  = 5'd7;
  localparam logic [4:0] PH_SOF_W_HI  = 5'd8;
  localparam logic [4:0] PH_SOF_W_LO  = 5'd9;
  localparam logic [4:0] PH_SOF_NC    = 5'd10;
  localparam logic [4:0] PH_SOF_CID   = 5'd11;
  localparam logic [4:0] PH_SOF_SAMP  = 5'd12;
  localparam logic [4:0] PH_SOF_QT    = 5'd13;
  localparam logic [4:0] PH_DQT_INFO  = 5'd14;
  localparam logic [4:0] PH_DQT_ENTRY = 5'd15;
  localparam logic [4:0] PH_DHT_INFO  = 5'd16;
  localparam logic [4:0] PH_DHT_COUNT = 5'd17;
  localparam logic [4:0] PH_DHT_SYM   = 5'd18;
  localparam logic [4:0] PH_DRI_HI    = 5'd19;
  localparam logic [4:0] PH_DRI_LO    = 5'd20;
  localparam logic [4:0] PH_SOS_N     = 5'd21;
  localparam logic [4:0] PH_SOS_CID   = 5'd22;
  localparam logic [4:0] PH_SOS_TBL   = 5'd23;
  localparam logic [4:0] PH_SOS_TAIL  = 5'd24;
  localparam logic [4:0] PH_APP0_ID   = 5'd25;

  typedef struct packed {
    logic [3:0]  kind;
    logic        table_class;
    logic [1:0]  table_id;
    logic [7:0]  position;
    logic [15:0] value;
    logic [7:0]  comp_id;
    logic [3:0]  samp_h;
    logic [3:0]  samp_v;
    logic [3:0]  dc_table;
    logic [3:0]  ac_table;
    logic [2:0]  error_code;
  } result_t;

  // JFIF identifier, one letter per position
  function automatic logic [7:0] jfif_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h4A;
      2'd1: c = 8'h46;
      2'd2: c = 8'h49;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: sv/jhmp_core.sv
// Parse state registers and the per-byte next-state and result logic.
`default_nettype none
module jhmp_core #(
  parameter int MAX_COMPONENTS = jhmp_pkg::MaxComponents
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_en,
  input  wire logic [7:0]        data_byte,
  output logic                   res_valid,
  output jhmp_pkg::result_t      res
);

  localparam int CW = $clog2(MAX_COMPONENTS + 1);

  logic [4:0]  phase, phase_next;
  logic [15:0] segment_left, segment_left_next;
  logic [7:0]  step_count, step_count_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic [7:0]  component_ids [MAX_COMPONENTS];
  logic [7:0]  component_ids_next [MAX_COMPONENTS];
  logic [CW-1:0] component_total, component_total_next;
  logic [2:0]  current_table, current_table_next;
  logic [8:0]  symbol_total, symbol_total_next;
  logic        halted, halted_next;

  logic [15:0] left_dec, seg_len;
  logic        last, fail, complete;
  logic [2:0]  fail_code;
  logic [7:0]  step_inc, slot_id;
  logic [9:0]  sym_sum;
  logic        found;
  logic [2:0]  found_idx;
  jhmp_pkg::result_t r;

  always_comb begin
    slot_id = '0;
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      if (step_count == 8'(k)) slot_id = component_ids[k];
    end
    found = 1'b0;
    found_idx = '0;
    for (int k = MAX_COMPONENTS - 1; k >= 0; k--) begin
      if ((k < int'(component_total)) && (component_ids[k] == data_byte)) begin
        found = 1'b1;
        found_idx = 3'(k);
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    segment_left_next    = segment_left;
    step_count_next      = step_count;
    held_high_byte_next  = held_high_byte;
    component_ids_next   = component_ids;
    component_total_next = component_total;
    current_table_next   = current_table;
    symbol_total_next    = symbol_total;
    halted_next          = halted;
    r         = '0;
    res_valid = 1'b0;
    fail      = 1'b0;
    fail_code = jhmp_pkg::E_SOF;
    left_dec  = segment_left - 16'd1;
    last      = (left_dec == 16'd0);
    seg_len   = {held_high_byte, data_byte};
    step_inc  = step_count + 8'd1;
    sym_sum   = 10'(symbol_total) + 10'(data_byte);
    complete  = 1'b0;

    if (!halted) begin
      case (phase)
        jhmp_pkg::PH_SYNC: begin
          if (data_byte == jhmp_pkg::M_FILL) phase_next = jhmp_pkg::PH_MARKER;
        end
        jhmp_pkg::PH_MARKER: begin
          case (data_byte)
            jhmp_pkg::M_FILL: ;
            jhmp_pkg::M_TEM, jhmp_pkg::M_SOI: phase_next = jhmp_pkg::PH_SYNC;
            jhmp_pkg::M_EOI: begin
              fail = 1'b1; fail_code = jhmp_pkg::E_EOI;
            end
            jhmp_pkg::M_SOF0: begin
              step_count_next = 8'(jhmp_pkg::PH_SOF_PREC); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            jhmp_pkg::M_DHT: begin
              step_count_next = 8'(jhmp_pkg::PH_DHT_INFO); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            jhmp_pkg::M_SOS: begin
              step_count_next = 8'(jhmp_pkg::PH_SOS_N); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            jhmp_pkg::M_DQT: begin
              step_count_next = 8'(jhmp_pkg::PH_DQT_INFO); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            jhmp_pkg::M_DRI: begin
              step_count_next = 8'(jhmp_pkg::PH_DRI_HI); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            jhmp_pkg::M_APP0: begin
              step_count_next = 8'(jhmp_pkg::PH_APP0_ID); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            jhmp_pkg::M_SOF1, jhmp_pkg::M_SOF2, jhmp_pkg::M_SOF3,
            jhmp_pkg::M_SOF5, jhmp_pkg::M_SOF6, jhmp_pkg::M_SOF7: begin
              fail = 1'b1; fail_code = jhmp_pkg::E_SOF;
            end
            jhmp_pkg::M_JPG: begin
              step_count_next = 8'(jhmp_pkg::PH_SKIP); phase_next = jhmp_pkg::PH_LEN_HI;
            end
            default: begin
              if (data_byte[7:5] == 3'b111) begin
                step_count_next = 8'(jhmp_pkg::PH_SKIP);
                phase_next = jhmp_pkg::PH_LEN_HI;
              end else begin
                phase_next = jhmp_pkg::PH_SYNC;
                r.kind = jhmp_pkg::K_UNKNOWN;
                r.value = 16'(data_byte);
                res_valid = 1'b1;
              end
            end
          endcase
        end
        jhmp_pkg::PH_LEN_HI: begin
          held_high_byte_next = data_byte;
          phase_next = jhmp_pkg::PH_LEN_LO;
        end
        jhmp_pkg::PH_LEN_LO: begin
          segment_left_next = seg_len - 16'd2;
          step_count_next = '0;
          if (seg_len < 16'd2) begin
            fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
          end else if (seg_len == 16'd2) begin
            // empty segment: only table and skipped segments may be empty
            if (step_count[4:0] == jhmp_pkg::PH_SKIP || step_count[4:0] == jhmp_pkg::PH_DQT_INFO
                || step_count[4:0] == jhmp_pkg::PH_DHT_INFO) begin
              phase_next = jhmp_pkg::PH_SYNC;
            end else begin
              fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
            end
          end else begin
            phase_next = step_count[4:0];
          end
        end
        default: begin
          segment_left_next = left_dec;
          case (phase)
            jhmp_pkg::PH_SKIP: begin
              if (last) phase_next = jhmp_pkg::PH_SYNC;
            end
            jhmp_pkg::PH_SOF_PREC: begin
              if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              phase_next = jhmp_pkg::PH_SOF_H_HI;
              r.kind = jhmp_pkg::K_PREC; r.value = 16'(data_byte); res_valid = 1'b1;
            end
            jhmp_pkg::PH_SOF_H_HI, jhmp_pkg::PH_SOF_W_HI, jhmp_pkg::PH_SOF_CID,
            jhmp_pkg::PH_SOF_SAMP, jhmp_pkg::PH_DRI_HI: begin
              if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              if (phase == jhmp_pkg::PH_SOF_CID) begin
                for (int k = 0; k < MAX_COMPONENTS; k++) begin
                  if (step_count == 8'(k)) component_ids_next[k] = data_byte;
                end
              end else begin
                held_high_byte_next = data_byte;
              end
              phase_next = phase + 5'd1;
            end
            jhmp_pkg::PH_SOF_H_LO, jhmp_pkg::PH_SOF_W_LO: begin
              if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              phase_next = phase + 5'd1;
              r.kind = (phase == jhmp_pkg::PH_SOF_H_LO) ? jhmp_pkg::K_HEIGHT : jhmp_pkg::K_WIDTH;
              r.value = seg_len; res_valid = 1'b1;
            end
            jhmp_pkg::PH_SOF_NC: begin
              if (data_byte == 8'd0 || 9'(data_byte) > 9'(MAX_COMPONENTS)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_COUNT;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              component_total_next = CW'(data_byte);
              step_count_next = '0;
              phase_next = jhmp_pkg::PH_SOF_CID;
              r.kind = jhmp_pkg::K_NCOMP; r.value = 16'(data_byte); res_valid = 1'b1;
            end
            jhmp_pkg::PH_SOF_QT: begin
              complete = (9'(step_count) + 9'd1 >= 9'(component_total));
              if (data_byte >= 8'(jhmp_pkg::QuantTables)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_TABLE;
              end else if (last != complete) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              r.kind = jhmp_pkg::K_COMP; r.value = 16'(data_byte);
              r.position = step_count; r.comp_id = slot_id;
              r.samp_h = held_high_byte[7:4]; r.samp_v = held_high_byte[3:0];
              r.table_id = data_byte[1:0]; res_valid = 1'b1;
              step_count_next = step_inc;
              phase_next = complete ? jhmp_pkg::PH_SYNC : jhmp_pkg::PH_SOF_CID;
            end
            jhmp_pkg::PH_DQT_INFO: begin
              if (data_byte[7:4] != 4'd0 || 8'(data_byte[3:0]) >= 8'(jhmp_pkg::QuantTables)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_TABLE;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              current_table_next = data_byte[2:0];
              step_count_next = '0;
              phase_next = jhmp_pkg::PH_DQT_ENTRY;
            end
            jhmp_pkg::PH_DQT_ENTRY: begin
              complete = (9'(step_count) + 9'd1 >= 9'(jhmp_pkg::BlockEntries));
              if (last && !complete) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              r.kind = jhmp_pkg::K_QUANT; r.value = 16'(data_byte);
              r.table_id = current_table[1:0]; r.position = step_count; res_valid = 1'b1;
              step_count_next = step_inc;
              if (complete) phase_next = last ? jhmp_pkg::PH_SYNC : jhmp_pkg::PH_DQT_INFO;
            end
            jhmp_pkg::PH_DHT_INFO: begin
              if (data_byte[7:5] != 3'd0 || 8'(data_byte[3:0]) >= 8'(jhmp_pkg::HuffTables)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_TABLE;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              current_table_next = {1'b0, data_byte[4], data_byte[0]};
              symbol_total_next = '0;
              step_count_next = '0;
              phase_next = jhmp_pkg::PH_DHT_COUNT;
            end
            jhmp_pkg::PH_DHT_COUNT: begin
              symbol_total_next = sym_sum[8:0];
              step_count_next = step_inc;
              if (sym_sum > 10'(jhmp_pkg::HuffSymLimit)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_TABLE;
              end else if (step_inc >= 8'(jhmp_pkg::HuffLengths)) begin
                step_count_next = '0;
                if (sym_sum == 10'd0) begin
                  phase_next = last ? jhmp_pkg::PH_SYNC : jhmp_pkg::PH_DHT_INFO;
                end else if (last) begin
                  fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
                end else begin
                  phase_next = jhmp_pkg::PH_DHT_SYM;
                end
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              r.kind = jhmp_pkg::K_HCOUNT; r.value = 16'(data_byte);
              r.table_class = current_table[1]; r.table_id = {1'b0, current_table[0]};
              r.position = step_count; res_valid = 1'b1;
            end
            jhmp_pkg::PH_DHT_SYM: begin
              complete = (9'(step_count) + 9'd1 >= symbol_total);
              if (last && !complete) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              r.kind = jhmp_pkg::K_HSYM; r.value = 16'(data_byte);
              r.table_class = current_table[1]; r.table_id = {1'b0, current_table[0]};
              r.position = step_count; res_valid = 1'b1;
              step_count_next = step_inc;
              if (complete) phase_next = last ? jhmp_pkg::PH_SYNC : jhmp_pkg::PH_DHT_INFO;
            end
            jhmp_pkg::PH_DRI_LO: begin
              if (!last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              phase_next = jhmp_pkg::PH_SYNC;
              r.kind = jhmp_pkg::K_RESTART; r.value = seg_len; res_valid = 1'b1;
            end
            jhmp_pkg::PH_SOS_N: begin
              if (data_byte == 8'd0 || 9'(data_byte) != 9'(component_total)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_COUNT;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              step_count_next = '0;
              phase_next = jhmp_pkg::PH_SOS_CID;
            end
            jhmp_pkg::PH_SOS_CID: begin
              if (!found) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_SCANID;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              held_high_byte_next = data_byte;
              current_table_next = found_idx;
              phase_next = jhmp_pkg::PH_SOS_TBL;
            end
            jhmp_pkg::PH_SOS_TBL: begin
              if (8'(data_byte[7:4]) >= 8'(jhmp_pkg::HuffTables)
                  || 8'(data_byte[3:0]) >= 8'(jhmp_pkg::HuffTables)) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_TABLE;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
              r.kind = jhmp_pkg::K_SCAN; r.position = 8'(current_table);
              r.comp_id = held_high_byte; r.dc_table = data_byte[7:4];
              r.ac_table = data_byte[3:0]; res_valid = 1'b1;
              if (9'(step_inc) >= 9'(component_total)) begin
                step_count_next = '0;
                phase_next = jhmp_pkg::PH_SOS_TAIL;
              end else begin
                step_count_next = step_inc;
                phase_next = jhmp_pkg::PH_SOS_CID;
              end
            end
            jhmp_pkg::PH_SOS_TAIL: begin
              step_count_next = step_inc;
              if (step_inc >= 8'd3) begin
                if (!last) begin
                  fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
                end
                halted_next = 1'b1;
                r.kind = jhmp_pkg::K_DONE; res_valid = 1'b1;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
            end
            jhmp_pkg::PH_APP0_ID: begin
              step_count_next = step_inc;
              if (data_byte != jhmp_pkg::jfif_char(step_count[1:0])) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_JFIF;
              end else if (step_inc >= 8'd4) begin
                phase_next = last ? jhmp_pkg::PH_SYNC : jhmp_pkg::PH_SKIP;
              end else if (last) begin
                fail = 1'b1; fail_code = jhmp_pkg::E_LENGTH;
              end
            end
            default: phase_next = jhmp_pkg::PH_SYNC;
          endcase
        end
      endcase
    end

    // an error replaces any other result and halts the parser
    if (fail) begin
      r = '0;
      r.kind = jhmp_pkg::K_ERROR;
      r.error_code = fail_code;
      res_valid = 1'b1;
      halted_next = 1'b1;
    end
    res = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= jhmp_pkg::PH_SYNC;
      segment_left    <= '0;
      step_count      <= '0;
      held_high_byte  <= '0;
      component_total <= '0;
      current_table   <= '0;
      symbol_total    <= '0;
      halted          <= 1'b0;
      for (int k = 0; k < MAX_COMPONENTS; k++) component_ids[k] <= '0;
    end else if (step_en) begin
      phase           <= phase_next;
      segment_left    <= segment_left_next;
      step_count      <= step_count_next;
      held_high_byte  <= held_high_byte_next;
      component_total <= component_total_next;
      current_table   <= current_table_next;
      symbol_total    <= symbol_total_next;
      halted          <= halted_next;
      component_ids   <= component_ids_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("parser left the halted state without reset");
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
      (step_en && res_valid && res.kind == jhmp_pkg::K_ERROR) |=> halted)
    else $error("error result did not halt the parser");
  a_done_halts: assert property (@(posedge clk) disable iff (rst)
      (step_en && res_valid && res.kind == jhmp_pkg::K_DONE) |=> halted)
    else $error("done result did not halt the parser");
  a_silent_halted: assert property (@(posedge clk) disable iff (rst) halted |-> !res_valid)
    else $error("result produced while halted");
`endif

endmodule
`default_nettype wire

FILE: sv/jhmp_out_reg.sv
// Result register that holds one result transaction until it is taken.
`default_nettype none
module jhmp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire jhmp_pkg::result_t load_data,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jhmp_pkg::result_t      data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= load_data;
  end

endmodule
`default_nettype wire

FILE: sv/jpeg_header_marker_parser.sv
// Top level of the JPEG header marker parser.
//  channel | signals                   | direction | payload
//  input   | in_valid / in_ready       | in        | data_byte
//  result  | out_valid / out_ready     | out       | kind .. error_code
// One header byte is taken per cycle while in_ready is high; its result, if any, is registered and
// shows on the result channel in the cycle after the byte is taken.
// The byte is taken whenever the result register is empty or being emptied,
// so a stall on the result side holds the input only while a result waits.
// Synchronous reset returns the parser to waiting for 0xFF; no clearing pass.
// After an error or the end of the scan header all further bytes are dropped.
`default_nettype none
module jpeg_header_marker_parser #(
  parameter int MAX_COMPONENTS = jhmp_pkg::MaxComponents
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       kind,
  output logic             table_class,
  output logic [1:0]       table_id,
  output logic [7:0]       position,
  output logic [15:0]      value,
  output logic [7:0]       comp_id,
  output logic [3:0]       samp_h,
  output logic [3:0]       samp_v,
  output logic [3:0]       dc_table,
  output logic [3:0]       ac_table,
  output logic [2:0]       error_code
);

  logic              step_en, res_valid;
  jhmp_pkg::result_t res, held;

  assign step_en = in_valid && in_ready;

  jhmp_core #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step_en),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  jhmp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step_en && res_valid),
    .load_data (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data      (held)
  );

  assign kind        = held.kind;
  assign table_class = held.table_class;
  assign table_id    = held.table_id;
  assign position    = held.position;
  assign value       = held.value;
  assign comp_id     = held.comp_id;
  assign samp_h      = held.samp_h;
  assign samp_v      = held.samp_v;
  assign dc_table    = held.dc_table;
  assign ac_table    = held.ac_table;
  assign error_code  = held.error_code;

endmodule
`default_nettype wire
